// ===== hw/rtl/line_rasterizer_defines.svh =====
// assertion macros for the line rasterizer top level
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LR_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("line rasterizer check failed");
`define LR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("line rasterizer check failed");
`else
`define LR_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define LR_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== hw/rtl/lr_pkg.sv =====
package lr_pkg;

  localparam int unsigned CoordBitsDefault = 10;
  localparam int unsigned StrideBits       = 13;
  localparam int unsigned AddrBits         = 32;
  localparam int unsigned ColorBits        = 8;
  localparam int unsigned CfgIdxBits       = 2;
  localparam int unsigned CfgDataBits      = 32;

  localparam logic [StrideBits-1:0] StrideReset = StrideBits'(720);
  localparam logic [AddrBits-1:0]   BaseReset   = '0;
  localparam logic                  ActiveReset = 1'b1;

  typedef enum logic [CfgIdxBits-1:0] {
    RegLineStride    = 2'd0,
    RegFrameBase     = 2'd1,
    RegDisplayActive = 2'd2
  } lr_reg_e;

  typedef enum logic {
    FuncStart = 1'b0,
    FuncStep  = 1'b1
  } lr_func_e;

  // control from the top level into the line core
  typedef struct packed {
    logic take;            // request leaves the input register this cycle
    logic drain;           // pixel register empties into the output stage
    logic display_active;
  } lr_ctrl_t;

  typedef struct packed {
    logic pix_valid;
    logic busy;
  } lr_stat_t;

endpackage

// ===== hw/rtl/lr_core.sv =====
module lr_core import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lr_ctrl_t             ctrl_i,
  input  lr_func_e             func_i,
  input  logic [CoordBits-1:0] x_first_i,
  input  logic [CoordBits-1:0] y_first_i,
  input  logic [CoordBits-1:0] x_second_i,
  input  logic [CoordBits-1:0] y_second_i,
  input  logic [ColorBits-1:0] pen_color_i,
  output logic [CoordBits-1:0] pix_x_o,
  output logic [CoordBits-1:0] pix_y_o,
  output logic [ColorBits-1:0] pix_color_o,
  output logic                 pix_last_o,
  output lr_stat_t             stat_o
);

  localparam int unsigned DecBits = CoordBits + 3;
  localparam int unsigned IncBits = CoordBits + 2;

  logic [CoordBits-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CoordBits-1:0] major_end_q, major_end_d;
  logic [DecBits-1:0]   decision_q, decision_d;
  logic [IncBits-1:0]   inc_straight_q, inc_straight_d;
  logic [DecBits-1:0]   inc_diagonal_q, inc_diagonal_d;
  logic                 minor_neg_q, minor_neg_d;
  logic                 x_major_q, x_major_d;
  logic                 busy_q, busy_d;
  logic [ColorBits-1:0] held_color_q, held_color_d;
  logic                 pix_valid_q, pix_valid_d;
  logic [CoordBits-1:0] pix_x_q, pix_y_q;
  logic [ColorBits-1:0] pix_color_q;
  logic                 pix_last_q;

  logic [CoordBits-1:0] dx, dy, dmaj, dmin, amaj, bmaj, amin, bmin;
  logic [CoordBits-1:0] smaj, smin, emaj, emin;
  logic                 x_major_new, swap;
  logic                 step_minor;
  logic [CoordBits-1:0] maj_cur, min_cur, maj_nxt, min_nxt;
  logic                 emit;

  always_comb begin
    // start: pick the major axis and the endpoint to run from
    dx = (x_first_i > x_second_i) ? x_first_i - x_second_i : x_second_i - x_first_i;
    dy = (y_first_i > y_second_i) ? y_first_i - y_second_i : y_second_i - y_first_i;
    x_major_new = dx > dy;
    amaj = x_major_new ? x_first_i  : y_first_i;
    bmaj = x_major_new ? x_second_i : y_second_i;
    amin = x_major_new ? y_first_i  : x_first_i;
    bmin = x_major_new ? y_second_i : x_second_i;
    dmaj = x_major_new ? dx : dy;
    dmin = x_major_new ? dy : dx;
    swap = amaj > bmaj;
    smaj = swap ? bmaj : amaj;
    smin = swap ? bmin : amin;
    emaj = swap ? amaj : bmaj;
    emin = swap ? amin : bmin;

    // step: one decision update
    step_minor = !decision_q[DecBits-1];
    maj_cur = x_major_q ? cur_x_q : cur_y_q;
    min_cur = x_major_q ? cur_y_q : cur_x_q;
    maj_nxt = maj_cur + CoordBits'(1);
    if (!step_minor) begin
      min_nxt = min_cur;
    end else if (minor_neg_q) begin
      min_nxt = min_cur - CoordBits'(1);
    end else begin
      min_nxt = min_cur + CoordBits'(1);
    end

    cur_x_d        = cur_x_q;
    cur_y_d        = cur_y_q;
    major_end_d    = major_end_q;
    decision_d     = decision_q;
    inc_straight_d = inc_straight_q;
    inc_diagonal_d = inc_diagonal_q;
    minor_neg_d    = minor_neg_q;
    x_major_d      = x_major_q;
    busy_d         = busy_q;
    held_color_d   = held_color_q;
    emit           = 1'b0;

    if (ctrl_i.take) begin
      case (func_i)
        FuncStart: begin
          if (!ctrl_i.display_active) begin
            busy_d = 1'b0;
          end else begin
            x_major_d      = x_major_new;
            major_end_d    = emaj;
            minor_neg_d    = emin < smin;
            cur_x_d        = x_major_new ? smaj : smin;
            cur_y_d        = x_major_new ? smin : smaj;
            busy_d         = smaj != emaj;
            decision_d     = (DecBits'(dmin) << 1) - DecBits'(dmaj);
            inc_straight_d = IncBits'(dmin) << 1;
            inc_diagonal_d = (DecBits'(dmin) - DecBits'(dmaj)) << 1;
            held_color_d   = pen_color_i;
            emit           = 1'b1;
          end
        end
        FuncStep: begin
          if (busy_q) begin
            decision_d = decision_q + (step_minor ? inc_diagonal_q
                                                  : DecBits'(inc_straight_q));
            cur_x_d    = x_major_q ? maj_nxt : min_nxt;
            cur_y_d    = x_major_q ? min_nxt : maj_nxt;
            busy_d     = maj_nxt != major_end_q;
            emit       = ctrl_i.display_active;
          end
        end
        default: ;
      endcase
    end

    if (ctrl_i.take) begin
      pix_valid_d = emit;
    end else if (ctrl_i.drain) begin
      pix_valid_d = 1'b0;
    end else begin
      pix_valid_d = pix_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      major_end_q    <= '0;
      decision_q     <= '0;
      inc_straight_q <= '0;
      inc_diagonal_q <= '0;
      minor_neg_q    <= 1'b0;
      x_major_q      <= 1'b0;
      busy_q         <= 1'b0;
      held_color_q   <= '0;
      pix_valid_q    <= 1'b0;
    end else begin
      cur_x_q        <= cur_x_d;
      cur_y_q        <= cur_y_d;
      major_end_q    <= major_end_d;
      decision_q     <= decision_d;
      inc_straight_q <= inc_straight_d;
      inc_diagonal_q <= inc_diagonal_d;
      minor_neg_q    <= minor_neg_d;
      x_major_q      <= x_major_d;
      busy_q         <= busy_d;
      held_color_q   <= held_color_d;
      pix_valid_q    <= pix_valid_d;
    end
  end

  // pixel payload follows the updated position
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && emit) begin
      pix_x_q     <= cur_x_d;
      pix_y_q     <= cur_y_d;
      pix_color_q <= held_color_d;
      pix_last_q  <= !busy_d;
    end
  end

  assign pix_x_o      = pix_x_q;
  assign pix_y_o      = pix_y_q;
  assign pix_color_o  = pix_color_q;
  assign pix_last_o   = pix_last_q;
  assign stat_o.pix_valid = pix_valid_q;
  assign stat_o.busy      = busy_q;

endmodule

// ===== hw/rtl/line_rasterizer.sv =====
// Bresenham line rasterizer. A start request (tuser 0) loads both endpoints and
// a pen color and yields the first pixel; each step request (tuser 1) yields the
// next pixel with its byte address frame_base + x + line_stride * y and tlast on
// the line's final pixel. Steps after the end, and every request while
// display_active is 0, give no pixel. One request is taken per clock while the
// output flows; each pixel is registered in the line core, then at the output.
// While a pixel waits at the output, requests are still taken until one more
// pixel is held in the line core and one request waits in the input register;
// requests that give no pixel pass the core in the meantime. The rate is set
// by the decision update in the line core, followed by a registered address
// stage holding the stride multiply. Configuration writes are taken at any
// time (cfg_ready_o is always high) but belong in idle periods.
`include "line_rasterizer_defines.svh"

module line_rasterizer import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDefault,
  localparam int unsigned InBits  = ((4 * CoordBits + ColorBits + 7) / 8) * 8,
  localparam int unsigned OutBits = ((2 * CoordBits + AddrBits + ColorBits + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // x_first, y_first, x_second, y_second, pen_color
  input  logic [InBits-1:0]      s_axis_tdata,
  // func
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pixel_x, pixel_y, pixel_address, pixel_color
  output logic [OutBits-1:0]     m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int unsigned ProdBits = StrideBits + CoordBits;

  logic [StrideBits-1:0] stride_q;
  logic [AddrBits-1:0]   base_q;
  logic                  display_active_q;

  logic                  in_valid_q, in_valid_d;
  lr_func_e              in_func_q;
  logic [CoordBits-1:0]  in_xf_q, in_yf_q, in_xs_q, in_ys_q;
  logic [ColorBits-1:0]  in_color_q;

  lr_ctrl_t              core_ctrl;
  lr_stat_t              core_stat;
  logic [CoordBits-1:0]  pix_x, pix_y;
  logic [ColorBits-1:0]  pix_color;
  logic                  pix_last;
  logic                  pix_ready, out_ready, s_accept;

  logic                  out_valid_q, out_valid_d;
  logic [CoordBits-1:0]  out_x_q, out_y_q;
  logic [AddrBits-1:0]   out_addr_q;
  logic [ColorBits-1:0]  out_color_q;
  logic                  out_last_q;
  logic [ProdBits-1:0]   row_off;
  logic [AddrBits-1:0]   addr;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q         <= StrideReset;
      base_q           <= BaseReset;
      display_active_q <= ActiveReset;
    end else if (cfg_valid_i) begin
      case (lr_reg_e'(cfg_index_i))
        RegLineStride:    stride_q         <= cfg_data_i[StrideBits-1:0];
        RegFrameBase:     base_q           <= cfg_data_i[AddrBits-1:0];
        RegDisplayActive: display_active_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake chain through the three stages
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign pix_ready     = !core_stat.pix_valid || out_ready;
  assign s_axis_tready = !in_valid_q || pix_ready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign core_ctrl.take           = in_valid_q && pix_ready;
  assign core_ctrl.drain          = core_stat.pix_valid && out_ready;
  assign core_ctrl.display_active = display_active_q;

  always_comb begin
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (core_ctrl.take) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    out_valid_d = out_ready ? core_stat.pix_valid : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_func_q  <= lr_func_e'(s_axis_tuser);
      in_xf_q    <= s_axis_tdata[CoordBits-1:0];
      in_yf_q    <= s_axis_tdata[2*CoordBits-1:CoordBits];
      in_xs_q    <= s_axis_tdata[3*CoordBits-1:2*CoordBits];
      in_ys_q    <= s_axis_tdata[4*CoordBits-1:3*CoordBits];
      in_color_q <= s_axis_tdata[4*CoordBits+ColorBits-1:4*CoordBits];
    end
  end

  lr_core #(
    .CoordBits(CoordBits)
  ) u_core (
    .clk_i,
    .rst_ni,
    .ctrl_i      (core_ctrl),
    .func_i      (in_func_q),
    .x_first_i   (in_xf_q),
    .y_first_i   (in_yf_q),
    .x_second_i  (in_xs_q),
    .y_second_i  (in_ys_q),
    .pen_color_i (in_color_q),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .pix_color_o (pix_color),
    .pix_last_o  (pix_last),
    .stat_o      (core_stat)
  );

  // address stage
  assign row_off = ProdBits'(stride_q) * ProdBits'(pix_y);
  assign addr    = base_q + AddrBits'(pix_x) + AddrBits'(row_off);

  always_ff @(posedge clk_i) begin
    if (core_ctrl.drain) begin
      out_x_q     <= pix_x;
      out_y_q     <= pix_y;
      out_addr_q  <= addr;
      out_color_q <= pix_color;
      out_last_q  <= pix_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutBits'({out_color_q, out_addr_q, out_y_q, out_x_q});
  assign m_axis_tlast  = out_last_q;

  `LR_ASSERT_NEXT(a_pix_holds, clk_i, rst_ni, core_stat.pix_valid && !out_ready, core_stat.pix_valid && $stable(pix_x) && $stable(pix_y))
  `LR_ASSERT_NEXT(a_in_holds, clk_i, rst_ni, in_valid_q && !core_ctrl.take, in_valid_q)
  `LR_ASSERT_NEXT(a_off_start_quiet, clk_i, rst_ni, core_ctrl.take && !display_active_q && in_func_q == FuncStart, !core_stat.pix_valid && !core_stat.busy)
  `LR_ASSERT_NOW(a_full_blocks_input, clk_i, rst_ni, in_valid_q && !pix_ready, !s_axis_tready)

endmodule
